// ===== src/assert_macros.svh =====
// Assertion helper macros for the pid table checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication with asynchronous reset disable
`define PT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define PT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/pidt_pkg.sv =====
// ---------------------------------------------------------------------------
// pidt_pkg: shared types and constants of the pid table engine
// Command and result codes, sequencer states, default sizes.
// ---------------------------------------------------------------------------
`default_nettype none
package pidt_pkg;
  localparam int unsigned DefSlots = 128;
  localparam int unsigned DefFirst = 2;
  localparam int unsigned DefLast = 32767;
  localparam int unsigned BootPid = 1;
  localparam int unsigned PidW = 15;
  localparam int unsigned StatW = 32;
  localparam logic [StatW-1:0] BadStatus = 32'h0000_baad;

  typedef enum logic [2:0] {
    CMD_ALLOC = 3'd0, CMD_UNALLOC = 3'd1, CMD_DETACH = 3'd2,
    CMD_EXIT = 3'd3, CMD_JOIN = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    RC_OK = 3'd0, RC_FULL = 3'd1, RC_NOPID = 3'd2,
    RC_INVAL = 3'd3, RC_DEADLK = 3'd4, RC_PENDING = 3'd5
  } rc_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_EVAL, ST_SCAN_RD, ST_SCAN_EV,
    ST_SWEEP_RD, ST_SWEEP_EV, ST_SELF_RD, ST_SELF_EV, ST_OUT
  } state_e;

  // one table entry
  typedef struct packed {
    logic             used;
    logic [PidW-1:0]  pid;
    logic [PidW-1:0]  parent;
    logic             exited;
    logic             joinable;
    logic [StatW-1:0] status;
  } entry_t;
endpackage
`default_nettype wire

// ===== src/pidt_mem.sv =====
// ---------------------------------------------------------------------------
// pidt_mem: slot table storage
// One write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none
module pidt_mem
  import pidt_pkg::*;
#(
  parameter int unsigned Slots = DefSlots,
  localparam int unsigned AW = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  var  entry_t        wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output entry_t             rdata_o
);
  entry_t mem_q [Slots];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/process_id_table_engine.sv =====
// ---------------------------------------------------------------------------
// process_id_table_engine: process-id allocator table
// Allocate, unallocate, detach, exit and join on a slot table of pids.
// ---------------------------------------------------------------------------
// channel | valid   | stall   | payload
// cmd in  | valid_i | stall_o | cmd_i caller_pid_i target_pid_i exit_code_i ...
// result  | valid_o | stall_i | result_code_o new_pid_o exit_status_out_o ...
// Each command reads the slot table through one memory port, with a read
// state and an evaluate state per slot visited. After reset a clearing pass
// writes every entry; no command is taken meanwhile.
// A result beat waits in the output register while stall_i is high.
// ---------------------------------------------------------------------------
`default_nettype none
module process_id_table_engine
  import pidt_pkg::*;
#(
  parameter int unsigned TableSlots = DefSlots,
  parameter int unsigned FirstPid = DefFirst,
  parameter int unsigned LastPid = DefLast
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  output logic                         stall_o,
  input  wire logic [2:0]              cmd_i,
  input  wire logic [PidW-1:0]         caller_pid_i,
  input  wire logic [PidW-1:0]         target_pid_i,
  input  wire logic signed [StatW-1:0] exit_code_i,
  input  wire logic                    detach_children_i,
  input  wire logic                    no_hang_i,
  output logic                         valid_o,
  input  wire logic                    stall_i,
  output logic [2:0]                   result_code_o,
  output logic [PidW-1:0]              new_pid_o,
  output logic signed [StatW-1:0]      exit_status_out_o,
  output logic                         status_valid_o
);
  localparam int unsigned AW = (TableSlots > 1) ? $clog2(TableSlots) : 1;
  localparam int unsigned CW = $clog2(TableSlots + 1);
  localparam int unsigned Span = LastPid - FirstPid + 1;
  localparam int unsigned Bound = (Span < TableSlots) ? Span : TableSlots;
  localparam logic [PidW-1:0] FirstP = PidW'(FirstPid);
  localparam logic [PidW-1:0] LastP = PidW'(LastPid);
  localparam logic [PidW-1:0] BootP = PidW'(BootPid);
  localparam logic [AW-1:0] BootSlot = AW'(BootPid % TableSlots);

  state_e state_q, state_d;
  logic [2:0] cmd_q;
  logic [PidW-1:0] caller_q, target_q, cand_q, cand_d, p_q, p_d;
  logic [StatW-1:0] code_q;
  logic dodet_q, nohang_q;
  logic [CW-1:0] used_q, used_d, cnt_q, cnt_d;
  logic [2:0] rc_q, rc_d;
  logic [PidW-1:0] npid_q, npid_d;
  logic [StatW-1:0] st_q, st_d;
  logic sv_q, sv_d, ovalid_q, ovalid_d;
  logic [AW-1:0] addr_q, addr_d, raddr;
  logic we;
  logic [AW-1:0] waddr;
  entry_t wdata, rd;

  pidt_mem #(.Slots(TableSlots)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rd)
  );

  // slot index of a pid (power of two is a mask, else modulo by constant)
  function automatic logic [AW-1:0] slot_of(input logic [PidW-1:0] p);
    return AW'(p % PidW'(TableSlots));
  endfunction

  function automatic logic [PidW-1:0] nxt(input logic [PidW-1:0] p);
    return (p >= LastP) ? FirstP : p + 1'b1;
  endfunction

  logic hit;
  assign hit = rd.used && (rd.pid == target_q) && (target_q != '0);

  entry_t freed;
  assign freed = '0;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      used_q   <= CW'(1);
      cand_q   <= FirstP;
      ovalid_q <= 1'b0;
      addr_q   <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      cand_q   <= cand_d;
      ovalid_q <= ovalid_d;
      addr_q   <= addr_d;
      cnt_q    <= cnt_d;
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && valid_i) begin
      cmd_q    <= cmd_i;
      caller_q <= caller_pid_i;
      target_q <= (cmd_i == CMD_EXIT) ? caller_pid_i : target_pid_i;
      code_q   <= exit_code_i;
      dodet_q  <= detach_children_i;
      nohang_q <= no_hang_i;
    end
    p_q    <= p_d;
    rc_q   <= rc_d;
    npid_q <= npid_d;
    st_q   <= st_d;
    sv_q   <= sv_d;
  end

  // sequencer
  always_comb begin
    state_d = state_q; used_d = used_q; cand_d = cand_q; ovalid_d = ovalid_q;
    addr_d = addr_q; cnt_d = cnt_q; p_d = p_q;
    rc_d = rc_q; npid_d = npid_q; st_d = st_q; sv_d = sv_q;
    we = 1'b0; waddr = addr_q; wdata = rd; raddr = addr_q;
    if (ovalid_q && !stall_i) ovalid_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        we = 1'b1; wdata = '0;
        if (addr_q == BootSlot) begin
          wdata.used = 1'b1; wdata.pid = BootP; wdata.joinable = 1'b1;
          wdata.status = BadStatus;
        end
        addr_d = addr_q + 1'b1;
        if (addr_q == AW'(TableSlots - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (valid_i && !ovalid_q) begin
          rc_d = RC_INVAL; npid_d = '0; st_d = '0; sv_d = 1'b0;
          state_d = ST_OUT;
          case (cmd_i)
            CMD_ALLOC: begin
              if (caller_pid_i != '0) begin
                if (used_q >= CW'(TableSlots)) rc_d = RC_FULL;
                else begin
                  p_d = cand_q; cnt_d = '0; addr_d = slot_of(cand_q);
                  state_d = ST_SCAN_RD;
                end
              end
            end
            CMD_UNALLOC: begin
              if (target_pid_i >= FirstP && target_pid_i <= LastP) begin
                addr_d = slot_of(target_pid_i); state_d = ST_RD;
              end
            end
            CMD_DETACH, CMD_JOIN: begin
              addr_d = slot_of(target_pid_i); state_d = ST_RD;
            end
            CMD_EXIT: begin
              addr_d = slot_of(caller_pid_i); state_d = ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RD: state_d = ST_EVAL;
      ST_EVAL: begin
        state_d = ST_OUT;
        if (!hit) rc_d = RC_NOPID;
        else begin
          case (cmd_q)
            CMD_UNALLOC: begin
              if (rd.exited || rd.parent != caller_q) rc_d = RC_INVAL;
              else begin
                we = 1'b1; wdata = freed; used_d = used_q - 1'b1; rc_d = RC_OK;
              end
            end
            CMD_DETACH, CMD_JOIN: begin
              if (cmd_q == CMD_JOIN && (!rd.joinable || target_q == BootP))
                rc_d = RC_INVAL;
              else if (cmd_q == CMD_JOIN && target_q == caller_q) rc_d = RC_DEADLK;
              else if (cmd_q == CMD_JOIN && !rd.exited)
                rc_d = nohang_q ? RC_OK : RC_PENDING;
              else begin
                if (cmd_q == CMD_JOIN) begin
                  st_d = rd.status; sv_d = 1'b1;
                end
                if (!rd.joinable || rd.parent != caller_q || rd.parent == '0 ||
                    rd.parent == BootP) rc_d = RC_INVAL;
                else begin
                  rc_d = RC_OK; we = 1'b1; wdata.joinable = 1'b0;
                  if (rd.exited) begin
                    wdata = freed; used_d = used_q - 1'b1;
                  end
                end
              end
            end
            CMD_EXIT: begin
              rc_d = RC_OK; we = 1'b1;
              wdata.status = code_q; wdata.exited = 1'b1;
              if (dodet_q) begin
                addr_d = '0; state_d = ST_SWEEP_RD;
              end else if (!rd.joinable) begin
                wdata = freed; used_d = used_q - 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN_EV;
      ST_SCAN_EV: begin
        if (!rd.used) begin
          we = 1'b1;
          wdata = '{used: 1'b1, pid: p_q, parent: caller_q, exited: 1'b0,
                    joinable: 1'b1, status: BadStatus};
          used_d = used_q + 1'b1; cand_d = nxt(p_q); npid_d = p_q; rc_d = RC_OK;
          state_d = ST_OUT;
        end else if (cnt_q == CW'(Bound - 1)) begin
          rc_d = RC_FULL; state_d = ST_OUT;
        end else begin
          cnt_d = cnt_q + 1'b1; p_d = nxt(p_q); addr_d = slot_of(nxt(p_q));
          state_d = ST_SCAN_RD;
        end
      end
      ST_SWEEP_RD: state_d = ST_SWEEP_EV;
      ST_SWEEP_EV: begin
        // detach each joinable child of the caller unless the caller is the boot pid or zero; free exited ones
        if (rd.used && rd.parent == caller_q && rd.joinable &&
            caller_q != BootP && caller_q != '0) begin
          we = 1'b1; wdata.joinable = 1'b0;
          if (rd.exited) begin
            wdata = freed; used_d = used_q - 1'b1;
          end
        end
        addr_d = addr_q + 1'b1;
        if (addr_q == AW'(TableSlots - 1)) begin
          addr_d = slot_of(caller_q); state_d = ST_SELF_RD;
        end else state_d = ST_SWEEP_RD;
      end
      ST_SELF_RD: state_d = ST_SELF_EV;
      ST_SELF_EV: begin
        if (rd.used && rd.pid == caller_q && !rd.joinable) begin
          we = 1'b1; wdata = freed; used_d = used_q - 1'b1;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_q || !stall_i) begin
          ovalid_d = 1'b1; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign stall_o = (state_q != ST_IDLE) || ovalid_q;
  assign valid_o = ovalid_q;
  assign result_code_o = rc_q;
  assign new_pid_o = npid_q;
  assign exit_status_out_o = st_q;
  assign status_valid_o = sv_q;
endmodule
`default_nettype wire

// ===== src/pidt_chk.sv =====
// ---------------------------------------------------------------------------
// pidt_chk: port checker for the pid table engine
// Watches handshake and result fields on the top-level ports.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module pidt_chk
  import pidt_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            valid_i,
  input wire logic            stall_o,
  input wire logic            valid_o,
  input wire logic            stall_i,
  input wire logic [2:0]      result_code_o,
  input wire logic [PidW-1:0] new_pid_o,
  input wire logic            status_valid_o
);
  // an accepted command blocks the next one in the following cycle
  `PT_ASSERT_NXT(a_busy, clk_i, rst_ni, valid_i && !stall_o, stall_o, "accept not busy")
  // stalled result stays
  `PT_ASSERT_NXT(a_hold, clk_i, rst_ni, valid_o && stall_i, valid_o, "result dropped")
  // a pid is only given with ok
  `PT_ASSERT_IMP(a_pid, clk_i, rst_ni, valid_o && new_pid_o != '0,
                 result_code_o == RC_OK, "pid without ok")
  // result code in range
  `PT_ASSERT_IMP(a_rc, clk_i, rst_ni, valid_o,
                 result_code_o <= RC_PENDING, "bad result code")
  // no status with pending
  `PT_ASSERT_IMP(a_sv, clk_i, rst_ni, valid_o && status_valid_o,
                 result_code_o != RC_PENDING, "status with pending")
endmodule

bind process_id_table_engine pidt_chk u_pidt_chk (
  .clk_i, .rst_ni, .valid_i, .stall_o, .valid_o, .stall_i,
  .result_code_o, .new_pid_o, .status_valid_o
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the process-id table engine
// Drives allocate, unallocate, detach, exit and join commands under random
// idling and stalls, and checks every result beat against a built-in model
// of the pid table.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import pidt_pkg::*;

  localparam int unsigned Slots = DefSlots;
  localparam int unsigned WdogLimit = 200000;

  typedef struct {
    logic [2:0]        cmd;
    logic [PidW-1:0]   caller;
    logic [PidW-1:0]   target;
    logic [StatW-1:0]  code;
    logic              det;
    logic              nohang;
  } cmd_beat_t;

  typedef struct {
    logic [2:0]        rc;
    logic [PidW-1:0]   npid;
    logic [StatW-1:0]  status;
    logic              sv;
  } res_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic [2:0] cmd_i = '0;
  logic [PidW-1:0] caller_pid_i = '0;
  logic [PidW-1:0] target_pid_i = '0;
  logic signed [StatW-1:0] exit_code_i = '0;
  logic detach_children_i = 1'b0;
  logic no_hang_i = 1'b0;
  logic stall_o, valid_o, status_valid_o;
  logic [2:0] result_code_o;
  logic [PidW-1:0] new_pid_o;
  logic signed [StatW-1:0] exit_status_out_o;

  process_id_table_engine i_dut (
    .clk_i, .rst_ni, .valid_i, .stall_o, .cmd_i, .caller_pid_i, .target_pid_i,
    .exit_code_i, .detach_children_i, .no_hang_i, .valid_o, .stall_i,
    .result_code_o, .new_pid_o, .exit_status_out_o, .status_valid_o
  );

  always #10 clk_i = ~clk_i;

  // pid table shadow
  logic             t_used [Slots];
  logic [PidW-1:0]  t_pid [Slots];
  logic [PidW-1:0]  t_parent [Slots];
  logic             t_exited [Slots];
  logic             t_join [Slots];
  logic [StatW-1:0] t_status [Slots];
  int unsigned      cand, n_used;

  cmd_beat_t pending_cmds [$];
  res_beat_t expected_results [$];
  logic [PidW-1:0] live_pids [$];
  int unsigned idle_pct = 0, stall_pct = 0;
  int unsigned n_errors = 0, n_results = 0, wdog = 0;
  bit stim_done = 0;
  bit in_taken = 0;

  function automatic void table_reset();
    for (int i = 0; i < Slots; i++) begin
      t_used[i] = 0; t_pid[i] = '0; t_parent[i] = '0;
      t_exited[i] = 0; t_join[i] = 0; t_status[i] = '0;
    end
    t_used[BootPid % Slots] = 1;
    t_pid[BootPid % Slots] = PidW'(BootPid);
    t_join[BootPid % Slots] = 1;
    t_status[BootPid % Slots] = BadStatus;
    cand = DefFirst;
    n_used = 1;
  endfunction

  function automatic int find_slot(logic [PidW-1:0] p);
    int s;
    s = p % Slots;
    if (p == 0 || !t_used[s] || t_pid[s] != p) return -1;
    return s;
  endfunction

  function automatic void drop_slot(int s);
    t_used[s] = 0; t_pid[s] = '0; t_parent[s] = '0;
    t_exited[s] = 0; t_join[s] = 0; t_status[s] = '0;
    if (n_used > 0) n_used--;
  endfunction

  function automatic int unsigned step_pid(int unsigned p);
    return (p + 1 > DefLast) ? DefFirst : p + 1;
  endfunction

  function automatic rc_e detach_child(logic [PidW-1:0] child, logic [PidW-1:0] caller);
    int s;
    s = find_slot(child);
    if (s < 0) return RC_NOPID;
    if (!t_join[s] || t_parent[s] != caller || t_parent[s] == 0 ||
        t_parent[s] == BootPid) return RC_INVAL;
    t_join[s] = 0;
    if (t_exited[s]) drop_slot(s);
    return RC_OK;
  endfunction

  // predicts one result beat and updates the shadow table
  function automatic res_beat_t apply_command(cmd_beat_t c);
    res_beat_t r;
    int s;
    int unsigned p;
    bit found;
    r = '{rc: RC_INVAL, npid: '0, status: '0, sv: 0};
    case (c.cmd)
      CMD_ALLOC: begin
        if (c.caller == 0) r.rc = RC_INVAL;
        else if (n_used >= Slots) r.rc = RC_FULL;
        else begin
          p = cand;
          found = 0;
          for (int i = 0; i < Slots; i++) begin
            if (!t_used[p % Slots]) begin
              found = 1;
              break;
            end
            p = step_pid(p);
          end
          if (!found) r.rc = RC_FULL;
          else begin
            s = p % Slots;
            t_used[s] = 1; t_pid[s] = PidW'(p); t_parent[s] = c.caller;
            t_exited[s] = 0; t_join[s] = 1; t_status[s] = BadStatus;
            n_used++;
            cand = step_pid(p);
            r.npid = PidW'(p);
            r.rc = RC_OK;
          end
        end
      end
      CMD_UNALLOC: begin
        if (c.target < DefFirst || c.target > DefLast) r.rc = RC_INVAL;
        else begin
          s = find_slot(c.target);
          if (s < 0) r.rc = RC_NOPID;
          else if (t_exited[s] || t_parent[s] != c.caller) r.rc = RC_INVAL;
          else begin
            drop_slot(s);
            r.rc = RC_OK;
          end
        end
      end
      CMD_DETACH: r.rc = detach_child(c.target, c.caller);
      CMD_EXIT: begin
        s = find_slot(c.caller);
        if (s < 0) r.rc = RC_NOPID;
        else begin
          t_status[s] = c.code;
          t_exited[s] = 1;
          if (c.det) begin
            for (int i = 0; i < Slots; i++)
              if (t_used[i] && t_parent[i] == c.caller)
                void'(detach_child(t_pid[i], c.caller));
          end
          if (t_used[s] && t_pid[s] == c.caller && !t_join[s]) begin
            t_parent[s] = '0;
            drop_slot(s);
          end
          r.rc = RC_OK;
        end
      end
      CMD_JOIN: begin
        s = find_slot(c.target);
        if (s < 0) r.rc = RC_NOPID;
        else if (!t_join[s] || c.target == BootPid) r.rc = RC_INVAL;
        else if (c.target == c.caller) r.rc = RC_DEADLK;
        else if (!t_exited[s]) r.rc = c.nohang ? RC_OK : RC_PENDING;
        else begin
          r.status = t_status[s];
          r.sv = 1;
          r.rc = detach_child(c.target, c.caller);
        end
      end
      default: r.rc = RC_INVAL;
    endcase
    return r;
  endfunction

  // mostly pids that exist in the table, sometimes anything
  function automatic logic [PidW-1:0] pick_pid();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) begin
      for (int j = 0; j < 8; j++) begin
        int s;
        s = $urandom_range(0, Slots - 1);
        if (t_used[s]) return t_pid[s];
      end
      return PidW'(BootPid);
    end
    if (k == 7) return PidW'($urandom_range(0, 3));
    return PidW'($urandom);
  endfunction

  function automatic cmd_beat_t rand_cmd();
    cmd_beat_t c;
    int k;
    k = $urandom_range(0, 99);
    c.cmd = k < 30 ? CMD_ALLOC : k < 40 ? CMD_UNALLOC : k < 55 ? CMD_DETACH :
            k < 75 ? CMD_EXIT : k < 98 ? CMD_JOIN : 3'($urandom_range(5, 7));
    c.caller = pick_pid();
    c.target = pick_pid();
    c.code = $urandom;
    c.det = $urandom_range(0, 1);
    c.nohang = $urandom_range(0, 1);
    return c;
  endfunction

  function automatic cmd_beat_t mk(logic [2:0] cmd, int caller, int target,
                                   logic [31:0] code, bit det, bit nh);
    cmd_beat_t c;
    c.cmd = cmd; c.caller = PidW'(caller); c.target = PidW'(target);
    c.code = code; c.det = det; c.nohang = nh;
    return c;
  endfunction

  // command driver: new beats change at the falling edge once the last one is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!valid_i || in_taken) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          cmd_beat_t c;
          c = pending_cmds.pop_front();
          cmd_i <= c.cmd; caller_pid_i <= c.caller; target_pid_i <= c.target;
          exit_code_i <= c.code; detach_children_i <= c.det; no_hang_i <= c.nohang;
          valid_i <= 1'b1;
          expected_results.push_back(apply_command(c));
        end else begin
          valid_i <= 1'b0;
        end
      end
      stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= valid_i && !stall_o;
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) wdog <= 0;
      else wdog <= wdog + 1;
      if (valid_o && !stall_i) begin
        n_results <= n_results + 1;
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("ERROR: unexpected result beat rc=%0d", result_code_o);
        end else begin
          res_beat_t e;
          e = expected_results.pop_front();
          if (result_code_o !== e.rc || new_pid_o !== e.npid ||
              exit_status_out_o !== e.status || status_valid_o !== e.sv) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR: rc/pid/status/sv exp %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                       e.rc, e.npid, e.status, e.sv, result_code_o, new_pid_o,
                       exit_status_out_o, status_valid_o);
          end
        end
      end
      if (wdog >= WdogLimit) begin
        $display("Timeout after %0d idle cycles", wdog);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || expected_results.size() > 0 || valid_i)
      @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall, int n);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      while (pending_cmds.size() > 4) @(posedge clk_i);
      pending_cmds.push_back(rand_cmd());
    end
  endtask

  initial begin
    table_reset();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: boot pid, invalid callers, range edges, every command
    pending_cmds.push_back(mk(CMD_ALLOC, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_ALLOC, 1, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_ALLOC, 2, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_ALLOC, 32767, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_UNALLOC, 1, 1, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_UNALLOC, 1, 32767, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_UNALLOC, 1, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_JOIN, 1, 1, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_JOIN, 2, 2, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_JOIN, 1, 2, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_JOIN, 1, 2, 0, 0, 1));
    pending_cmds.push_back(mk(CMD_DETACH, 1, 2, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_DETACH, 2, 4, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_EXIT, 4, 0, 32'h8000_0000, 0, 0));
    pending_cmds.push_back(mk(CMD_JOIN, 2, 4, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_EXIT, 3, 0, 32'h7fff_ffff, 0, 0));
    pending_cmds.push_back(mk(CMD_EXIT, 2, 0, 32'hffff_ffff, 1, 0));
    pending_cmds.push_back(mk(CMD_EXIT, 9999, 0, 0, 1, 0));
    pending_cmds.push_back(mk(CMD_UNALLOC, 2, 3, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_UNALLOC, 32767, 32767, 0, 0, 0));
    pending_cmds.push_back(mk(3'd5, 1, 1, 0, 0, 0));
    pending_cmds.push_back(mk(3'd7, 32767, 32767, 32'h5555_aaaa, 1, 1));
    wait_drained();

    // fill the table to hit the full case, then random traffic
    repeat (Slots + 2) pending_cmds.push_back(mk(CMD_ALLOC, 1, 0, 0, 0, 0));
    run_phase(0, 0, 150);
    run_phase(64, 0, 150);
    run_phase(0, 64, 150);
    run_phase(25, 25, 150);
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d result beats, directed edges, full table and all idle mixes",
             n_results);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
